/* hdl/sorted_list_insert_delete_read_macros.svh */
// Assertion macros for the sorted list block.
// Used by the top level; relies on signals named clock and reset in the including module.
`ifndef SORTED_LIST_INSERT_DELETE_READ_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_READ_MACROS_SVH
`ifndef ASSERT_OFF
`define SL_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define SL_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SL_ASSERT_ALWAYS(label, expr, msg)
`define SL_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

/* hdl/sl_pkg.sv */
// Package for the sorted list block: sizes, action and status codes, cell control type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sl_pkg;
   localparam int DEPTH    = 64;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int VAL_W    = 32;
   localparam int ACT_W    = 2;
   localparam int POS_W    = 7;
   localparam int ST_W     = 2;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 48;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

   localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic                    insert_en;
      logic                    delete_en;
      logic signed [VAL_W-1:0] new_value;
      logic [CMP_W-1:0]        pos_idx;
      logic [CMP_W-1:0]        count;
   } cell_ctrl_type;
endpackage
`default_nettype wire

/* hdl/sl_cell.sv */
// One cell of the sorted row: holds one entry, shifts right on insert, left on delete.
// Depends on sl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sl_cell (
   input  wire                           clock,
   input  wire sl_pkg::cell_ctrl_type    ctrl,
   input  wire [sl_pkg::IDX_W-1:0]       cell_index,
   input  wire signed [sl_pkg::VAL_W-1:0] left_entry,
   input  wire                           left_after,
   input  wire signed [sl_pkg::VAL_W-1:0] right_entry,
   output logic signed [sl_pkg::VAL_W-1:0] entry,
   output logic                          after,
   output logic [sl_pkg::VAL_W-1:0]      read_data
);
   import sl_pkg::*;

   logic signed [VAL_W-1:0] entry_ff, entry_in;
   logic                    occupied;
   logic                    at_pos;
   logic                    past_pos;

   assign occupied = CMP_W'(cell_index) < ctrl.count;
   assign after    = !occupied || (entry_ff >= ctrl.new_value);
   assign at_pos   = CMP_W'(cell_index) == ctrl.pos_idx;
   assign past_pos = CMP_W'(cell_index) >= ctrl.pos_idx;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (left_after) begin
            entry_in = left_entry;
         end else if (after) begin
            entry_in = ctrl.new_value;
         end
      end else if (ctrl.delete_en && past_pos) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   assign read_data = at_pos ? entry_ff : '0;
endmodule
`default_nettype wire

/* hdl/sorted_list_insert_delete_read.sv */
// Top level of the sorted list: request decode, entry count, cell row, result register.
// Depends on sl_pkg, sl_cell and sorted_list_insert_delete_read_macros.svh.
//
// channel | dir | fields (low bit up)
// req     | in  | action[1:0] new_value[33:2] position[40:34]
// rsp     | out | read_value[31:0] status[33:32] entry_count[40:34]
//
// One word per cycle; the result appears the cycle after acceptance.
// All cells compare and shift together, so no request waits on another.
// A result held by a stalled rsp side stalls req only until it is taken.
// Reset clears the count and result valid; entries need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_insert_delete_read_macros.svh"
module sorted_list_insert_delete_read (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [sl_pkg::REQ_W-1:0]    req_tdata,   // action, new_value, position
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [sl_pkg::RSP_W-1:0]   rsp_tdata    // read_value, status, entry_count
);
   import sl_pkg::*;

   logic [ACT_W-1:0]        action;
   logic signed [VAL_W-1:0] new_value;
   logic [POS_W-1:0]        position;
   logic                    accept;
   logic                    full, empty, pos_ok;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        read_ff, read_in;
   logic [ST_W-1:0]         status_ff, status_in;
   logic [CNT_W-1:0]        rsp_count_ff;
   cell_ctrl_type           ctrl;
   logic [VAL_W-1:0]        read_or;
   logic                    insert_ok;
   logic                    rsp_full;

   logic signed [VAL_W-1:0] entries   [DEPTH];
   logic                    afters    [DEPTH];
   logic [VAL_W-1:0]        read_part [DEPTH];

   assign action    = req_tdata[1:0];
   assign new_value = req_tdata[33:2];
   assign position  = req_tdata[40:34];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full   = count_ff == CNT_W'(DEPTH);
   assign empty  = count_ff == '0;
   assign pos_ok = (position != '0) && (CMP_W'(position) <= CMP_W'(count_ff));

   always_comb begin
      ctrl.insert_en = 1'b0;
      ctrl.delete_en = 1'b0;
      ctrl.new_value = new_value;
      ctrl.pos_idx   = CMP_W'(position) - CMP_W'(1);
      ctrl.count     = CMP_W'(count_ff);
      count_in       = count_ff;
      status_in      = ST_DONE;
      case (action)
         ACT_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.insert_en = accept;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         ACT_DELETE, ACT_READ: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!pos_ok) begin
               status_in = ST_NOT_FOUND;
            end else if (action == ACT_DELETE) begin
               ctrl.delete_en = accept;
               count_in       = count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign read_in = (action == ACT_READ && !empty && pos_ok) ? read_or : '0;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         sl_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .cell_index  (IDX_W'(i)),
            .left_entry  ((i == 0) ? '0 : entries[(i == 0) ? 0 : i - 1]),
            .left_after  ((i == 0) ? 1'b0 : afters[(i == 0) ? 0 : i - 1]),
            .right_entry ((i == DEPTH - 1) ? '0 : entries[(i == DEPTH - 1) ? i : i + 1]),
            .entry       (entries[i]),
            .after       (afters[i]),
            .read_data   (read_part[i])
         );
      end
   endgenerate

   always_comb begin
      read_or = '0;
      for (int k = 0; k < DEPTH; k++) begin
         read_or = read_or | read_part[k];
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_ff      <= read_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, POS_W'(rsp_count_ff), status_ff, read_ff};

   assign insert_ok = accept && action == ACT_INSERT && !full;
   assign rsp_full  = rsp_valid_ff && status_ff == ST_FULL;

   `SL_ASSERT_ALWAYS(a_count_range, count_ff <= CNT_W'(DEPTH), "entry count above depth")
   `SL_ASSERT_IMPLY(a_insert_grows, insert_ok, count_ff == $past(count_ff) + CNT_W'(1), "count not grown")
   `SL_ASSERT_IMPLY(a_accept_valid, accept, rsp_valid_ff, "accepted word gave no result")
   `SL_ASSERT_ALWAYS(a_full_status, !rsp_full || rsp_count_ff == CNT_W'(DEPTH), "full with room left")
endmodule
`default_nettype wire

/* test/sorted_list_insert_delete_read_tb.sv */
// Self-checking bench for the sorted list: directed and random insert, delete and read words
// with random idling on both stream sides. Depends on sl_pkg and sorted_list_insert_delete_read.
`timescale 1ns / 1ps
module sorted_list_insert_delete_read_tb;
   import sl_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int WORD_TARGET = 1650;
   localparam int LONG_HOLD   = 300;
   localparam int QUIET_LIMIT = 4000;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [ST_W-1:0]         status;
      logic [POS_W-1:0]        entry_count;
   } list_result_type;

   // Mirror of the list contents plus the queue of results still owed.
   class list_book;
      logic signed [VAL_W-1:0] held[$];
      list_result_type         owed[$];
      int                      errors = 0;

      function void note_request(input logic [ACT_W-1:0] act,
                                 input logic signed [VAL_W-1:0] val,
                                 input logic [POS_W-1:0] pos);
         list_result_type r;
         int k;
         r.read_value = '0;
         r.status     = ST_DONE;
         case (act)
            ACT_INSERT: begin
               if (held.size() >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  k = 0;
                  // equal values go in front of existing ones
                  while (k < held.size() && held[k] < val) k++;
                  held.insert(k, val);
               end
            end
            ACT_DELETE, ACT_READ: begin
               if (held.size() == 0) begin
                  r.status = ST_EMPTY;
               end else if (pos == 0 || pos > held.size()) begin
                  r.status = ST_NOT_FOUND;
               end else if (act == ACT_READ) begin
                  r.read_value = held[pos - 1];
               end else begin
                  held.delete(pos - 1);
               end
            end
            default: ;
         endcase
         r.entry_count = POS_W'(held.size());
         owed.push_back(r);
      endfunction

      function void check_result(input logic [RSP_W-1:0] d);
         list_result_type e;
         list_result_type got;
         got.read_value  = d[31:0];
         got.status      = d[33:32];
         got.entry_count = d[40:34];
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word %h", $time, d);
            return;
         end
         e = owed.pop_front();
         if (got.read_value !== e.read_value) begin
            errors++;
            $display("%0t: read_value expected %0d got %0d", $time, e.read_value,
                     got.read_value);
         end
         if (got.status !== e.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
         end
         if (got.entry_count !== e.entry_count) begin
            errors++;
            $display("%0t: entry_count expected %0d got %0d", $time, e.entry_count,
                     got.entry_count);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   list_book book = new();
   bit idle_on = 1'b1;
   bit long_hold_pending = 1'b0;
   int word_total = 0;
   int rsp_stall_left = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_list_insert_delete_read dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3, 4: return 32'($urandom_range(0, 16)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input int n);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return POS_W'(n + 1);
         2: return POS_W'($urandom_range(0, 127));
         default: return (n == 0) ? POS_W'(1) : POS_W'($urandom_range(1, n));
      endcase
   endfunction

   // result side: random stalls, one long hold on request, checks every word taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         rsp_stall_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall_left = pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sorted_list_insert_delete_read_tb failed");
         $finish;
      end
   end

   task automatic send_word(input logic [ACT_W-1:0] act,
                            input logic signed [VAL_W-1:0] val,
                            input logic [POS_W-1:0] pos);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - 41){1'b0}}, pos, val, act};
      do @(posedge clock); while (!req_tready);
      book.note_request(act, val, pos);
      if (act != ACT_UNUSED) word_total++;
   endtask

   task automatic random_word(input int ins_pct, input int del_pct);
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = book.held.size();
      if (r < 3)
         send_word(ACT_UNUSED, $urandom, POS_W'($urandom_range(0, 127)));
      else if (r < 3 + ins_pct)
         send_word(ACT_INSERT, pick_value(), POS_W'($urandom_range(0, 127)));
      else if (r < 3 + ins_pct + del_pct)
         send_word(ACT_DELETE, $urandom, pick_position(n));
      else
         send_word(ACT_READ, $urandom, pick_position(n));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.owed.size() != 0);
   endtask

   task automatic fill_list();
      while (book.held.size() < DEPTH && word_total < WORD_TARGET) random_word(80, 8);
      repeat ($urandom_range(2, 6)) random_word(90, 0);
   endtask

   task automatic drain_list();
      while (book.held.size() > 0 && word_total < WORD_TARGET) random_word(5, 75);
      repeat ($urandom_range(3, 6)) random_word(10, 50);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, extremes, duplicates, bad positions, unused action
      send_word(ACT_READ,   '0, 7'd1);
      send_word(ACT_DELETE, '0, 7'd0);
      send_word(ACT_UNUSED, '0, 7'd0);
      send_word(ACT_INSERT, 32'sh7FFF_FFFF, 7'd0);
      send_word(ACT_INSERT, 32'sh8000_0000, 7'd0);
      send_word(ACT_INSERT, 32'sd0, 7'd0);
      send_word(ACT_INSERT, 32'sd0, 7'd127);
      send_word(ACT_INSERT, -32'sd1, 7'd0);
      send_word(ACT_INSERT, 32'sh7FFF_FFFF, 7'd0);
      send_word(ACT_READ,   '0, 7'd0);
      send_word(ACT_READ,   '0, 7'd1);
      send_word(ACT_READ,   '1, 7'd6);
      send_word(ACT_READ,   '0, 7'd7);
      send_word(ACT_READ,   '0, 7'd127);
      send_word(ACT_READ,   '0, 7'd64);
      send_word(ACT_DELETE, '0, 7'd3);
      send_word(ACT_DELETE, '0, 7'd0);
      send_word(ACT_DELETE, '1, 7'd100);
      send_word(ACT_UNUSED, '1, 7'd127);
      send_word(ACT_READ,   '0, 7'd3);
      send_word(ACT_DELETE, '0, 7'd1);
      send_word(ACT_DELETE, '0, 7'd4);
      send_word(ACT_READ,   '0, 7'd4);
      send_word(ACT_INSERT, 32'sd1, 7'd0);
      wait_drained();

      // back-pressure: result side holds off while words keep coming
      idle_on = 1'b0;
      long_hold_pending = 1'b1;
      fill_list();
      wait_drained();
      drain_list();

      while (word_total < WORD_TARGET) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 2))
            0: fill_list();
            1: drain_list();
            default: repeat ($urandom_range(20, 80)) random_word(45, 25);
         endcase
         if ($urandom_range(0, 2) == 0) wait_drained();
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (book.errors == 0 && book.owed.size() == 0) begin
         $display("sorted_list_insert_delete_read_tb passed");
      end else begin
         $display("sorted_list_insert_delete_read_tb failed");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+hdl
hdl/sl_pkg.sv
hdl/sl_cell.sv
hdl/sorted_list_insert_delete_read.sv
test/sorted_list_insert_delete_read_tb.sv
